// ===== design/sndx_pkg.sv =====
// Shared types, constants and the letter class table of the Soundex encoder.
`timescale 1ns / 1ps

package sndx_pkg;

	localparam int DigitWidth  = 3;
	localparam int ByteWidth   = 8;
	localparam int OutDigits   = 3;
	localparam int AlphaSize   = 26;

	localparam logic [ByteWidth-1:0] UpperA    = 8'h41;
	localparam logic [ByteWidth-1:0] UpperZ    = 8'h5A;
	localparam logic [ByteWidth-1:0] LowerA    = 8'h61;
	localparam logic [ByteWidth-1:0] LowerZ    = 8'h7A;
	localparam logic [ByteWidth-1:0] CaseShift = 8'h20;

	localparam logic [DigitWidth-1:0] ClassNone = 3'd0;

	typedef logic [DigitWidth-1:0] digit_t;

	// Class per letter, A first.
	localparam digit_t ClassTable [AlphaSize] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd5,
		3'd5, 3'd0, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd2
	};

	typedef struct packed {
		logic                 is_letter;
		logic [ByteWidth-1:0] upper;
		digit_t               cls;
	} sndx_letter_t;

	typedef struct packed {
		logic [ByteWidth-1:0] lead_letter;
		digit_t               digit_one;
		digit_t               digit_two;
		digit_t               digit_three;
		logic                 has_letter;
	} sndx_code_t;

endpackage

// ===== design/sndx_if.sv =====
// Valid/ready channel interfaces for the character input and the code output.
`timescale 1ns / 1ps

interface sndx_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface sndx_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] lead_letter;
	logic [2:0] digit_one;
	logic [2:0] digit_two;
	logic [2:0] digit_three;
	logic       has_letter;

	modport source (output valid, output lead_letter, output digit_one, output digit_two,
		output digit_three, output has_letter, input ready);
	modport sink   (input valid, input lead_letter, input digit_one, input digit_two,
		input digit_three, input has_letter, output ready);
endinterface

// ===== design/sndx_classify.sv =====
// Letter decode: case folding and class lookup for one byte.
`timescale 1ns / 1ps

module sndx_classify (
	input  logic [7:0]            char_in,
	output sndx_pkg::sndx_letter_t letter
);
	import sndx_pkg::*;

	logic                 is_lower;
	logic                 is_upper;
	logic [ByteWidth-1:0] up;
	logic [ByteWidth-1:0] offset;

	assign is_lower = (char_in >= LowerA) && (char_in <= LowerZ);
	assign is_upper = (char_in >= UpperA) && (char_in <= UpperZ);
	assign up       = is_lower ? (char_in - CaseShift) : char_in;
	assign offset   = up - UpperA;

	always_comb begin
		letter.is_letter = is_lower || is_upper;
		letter.upper     = up;
		// Non-letters index out of range; the index is truncated and the class ignored.
		if (letter.is_letter) begin
			letter.cls = ClassTable[offset[4:0]];
		end else begin
			letter.cls = ClassNone;
		end
	end

endmodule

// ===== design/sndx_accum.sv =====
// Per-name state: lead letter, previous class and the stored code digits.
`timescale 1ns / 1ps

module sndx_accum #(
	parameter int CODE_LENGTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   last_char,
	input  sndx_pkg::sndx_letter_t letter,
	output sndx_pkg::sndx_code_t   code
);
	import sndx_pkg::*;

	localparam int Slots = CODE_LENGTH - 1;
	localparam int CntW  = $clog2(CODE_LENGTH);

	logic                 seen_q,  seen_n;
	logic [ByteWidth-1:0] first_q, first_n;
	digit_t               prev_q,  prev_n;
	logic [CntW-1:0]      count_q, count_n;
	digit_t               store_q [Slots];
	digit_t               store_n [Slots];
	digit_t               digit_out [OutDigits];

	always_comb begin
		seen_n  = seen_q;
		first_n = first_q;
		prev_n  = prev_q;
		count_n = count_q;
		for (int k = 0; k < Slots; k++) begin
			store_n[k] = store_q[k];
		end
		if (letter.is_letter) begin
			if (!seen_q) begin
				seen_n  = 1'b1;
				first_n = letter.upper;
			end else if (letter.cls != prev_q && letter.cls != ClassNone &&
					count_q < CntW'(Slots)) begin
				for (int k = 0; k < Slots; k++) begin
					if (count_q == CntW'(k)) begin
						store_n[k] = letter.cls;
					end
				end
				count_n = count_q + CntW'(1);
			end
			prev_n = letter.cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			first_q <= '0;
			prev_q  <= ClassNone;
			count_q <= '0;
			for (int k = 0; k < Slots; k++) begin
				store_q[k] <= ClassNone;
			end
		end else if (step) begin
			if (last_char) begin
				seen_q  <= 1'b0;
				first_q <= '0;
				prev_q  <= ClassNone;
				count_q <= '0;
				for (int k = 0; k < Slots; k++) begin
					store_q[k] <= ClassNone;
				end
			end else begin
				seen_q  <= seen_n;
				first_q <= first_n;
				prev_q  <= prev_n;
				count_q <= count_n;
				for (int k = 0; k < Slots; k++) begin
					store_q[k] <= store_n[k];
				end
			end
		end
	end

	// Pad with zeros past the stored digits and past the slot count.
	for (genvar k = 0; k < OutDigits; k++) begin : g_digit
		if (k < Slots) begin : g_live
			assign digit_out[k] = (CntW'(k) < count_n) ? store_n[k] : ClassNone;
		end else begin : g_pad
			assign digit_out[k] = ClassNone;
		end
	end

	assign code.lead_letter = seen_n ? first_n : '0;
	assign code.digit_one   = digit_out[0];
	assign code.digit_two   = digit_out[1];
	assign code.digit_three = digit_out[2];
	assign code.has_letter  = seen_n;

endmodule

// ===== design/soundex_encoder_unit.sv =====
// Top level of the streaming Soundex encoder.
`timescale 1ns / 1ps

// Soundex encoder: feed a name one byte per beat on char_ch and mark its final
// byte with last_char. Bytes that are not ASCII letters are skipped. On the
// final byte one beat leaves on code_ch with the upper-case first letter,
// three code digits (0 where padded; CODE_LENGTH-1 digits are kept, at most
// three shown) and has_letter, which is 0 for a name with no letters (then all
// other fields are 0). Rate: one byte per clock, but for the stall below. A byte
// lands in the input register on the cycle it is accepted, and is then folded
// into the per-name state through one table lookup and compare; a final byte
// also loads the result register, from which the code leaves. The result
// register decouples the sides: bytes keep flowing while a code waits, and only
// a further final byte stalls behind an untaken code.
module soundex_encoder_unit #(
	parameter int CODE_LENGTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	sndx_char_if.sink   char_ch,
	sndx_code_if.source code_ch
);
	import sndx_pkg::*;

	// Input register stage.
	logic                 valid_s1;
	logic [ByteWidth-1:0] char_s1;
	logic                 last_s1;

	// Result register.
	logic                 out_valid_q;
	sndx_code_t           code_q;

	sndx_letter_t         letter;
	sndx_code_t           code_next;
	logic                 advance;
	logic                 step;

	// Stage 1 moves on unless it holds a final byte and the result register
	// is still full.
	assign advance = !last_s1 || !out_valid_q || code_ch.ready;
	assign step    = valid_s1 && advance;
	assign char_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ch.ready) begin
			valid_s1 <= char_ch.valid;
		end
	end

	// Payload needs no reset; hold while stalled.
	always_ff @(posedge clk) begin
		if (char_ch.ready && char_ch.valid) begin
			char_s1 <= char_ch.char_in;
			last_s1 <= char_ch.last_char;
		end
	end

	sndx_classify u_classify (
		.char_in (char_s1),
		.letter  (letter)
	);

	sndx_accum #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.last_char (last_s1),
		.letter    (letter),
		.code      (code_next)
	);

	// Load the result on a final byte; drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (code_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			code_q <= code_next;
		end
	end

	assign code_ch.valid       = out_valid_q;
	assign code_ch.lead_letter = code_q.lead_letter;
	assign code_ch.digit_one   = code_q.digit_one;
	assign code_ch.digit_two   = code_q.digit_two;
	assign code_ch.digit_three = code_q.digit_three;
	assign code_ch.has_letter  = code_q.has_letter;

endmodule
